FILE: design/tcs_pkg.sv
package tcs_pkg;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'd2;

  // Configuration register indexes
  localparam logic REG_TEXT_COLOR = 1'b0;

  // Sequencer steps
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] ST_INIT      = 4'd0;
  localparam logic [StepW-1:0] ST_IDLE      = 4'd1;
  localparam logic [StepW-1:0] ST_DEC_PUT   = 4'd2;
  localparam logic [StepW-1:0] ST_DEC_READ  = 4'd3;
  localparam logic [StepW-1:0] ST_DEC_CLEAR = 4'd4;
  localparam logic [StepW-1:0] ST_DEC_NONE  = 4'd5;
  localparam logic [StepW-1:0] ST_PUT       = 4'd6;
  localparam logic [StepW-1:0] ST_WRAP      = 4'd7;
  localparam logic [StepW-1:0] ST_SCROLL    = 4'd8;
  localparam logic [StepW-1:0] ST_BLANK     = 4'd9;
  localparam logic [StepW-1:0] ST_WRITE     = 4'd10;
  localparam logic [StepW-1:0] ST_NEWLINE   = 4'd11;
  localparam logic [StepW-1:0] ST_RD_ADDR   = 4'd12;
  localparam logic [StepW-1:0] ST_RD_CAP    = 4'd13;
  localparam logic [StepW-1:0] ST_CLEAR     = 4'd14;
  localparam logic [StepW-1:0] ST_RESULT    = 4'd15;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_ACCEPT,
    OP_WRAP,
    OP_SCROLL,
    OP_BLANK_ROW,
    OP_WRITE,
    OP_NEWLINE,
    OP_READ,
    OP_CAPTURE,
    OP_CLEAR,
    OP_RESULT
  } op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_ACC,
    C_CMD_PUT,
    C_CMD_READ,
    C_CMD_CLEAR,
    C_NEWLINE,
    C_NO_SCROLL,
    C_ROW_END,
    C_ALL_END,
    C_OUT_FREE
  } cond_e;

  // One control word: datapath operation, jump condition, stay-on-false flag,
  // jump target. A false condition without hold falls through to the next step.
  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic             hold;
    logic [StepW-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t w;
    unique case (step)
      ST_INIT:      w = '{OP_INIT,      C_ALL_END,   1'b1, ST_IDLE};
      ST_IDLE:      w = '{OP_ACCEPT,    C_IN_ACC,    1'b1, ST_DEC_PUT};
      ST_DEC_PUT:   w = '{OP_NONE,      C_CMD_PUT,   1'b0, ST_PUT};
      ST_DEC_READ:  w = '{OP_NONE,      C_CMD_READ,  1'b0, ST_RD_ADDR};
      ST_DEC_CLEAR: w = '{OP_NONE,      C_CMD_CLEAR, 1'b0, ST_CLEAR};
      ST_DEC_NONE:  w = '{OP_NONE,      C_ALWAYS,    1'b0, ST_RESULT};
      ST_PUT:       w = '{OP_NONE,      C_NEWLINE,   1'b0, ST_NEWLINE};
      ST_WRAP:      w = '{OP_WRAP,      C_ALWAYS,    1'b0, ST_SCROLL};
      ST_SCROLL:    w = '{OP_SCROLL,    C_NO_SCROLL, 1'b0, ST_WRITE};
      ST_BLANK:     w = '{OP_BLANK_ROW, C_ROW_END,   1'b1, ST_WRITE};
      ST_WRITE:     w = '{OP_WRITE,     C_ALWAYS,    1'b0, ST_RESULT};
      ST_NEWLINE:   w = '{OP_NEWLINE,   C_ALWAYS,    1'b0, ST_RESULT};
      ST_RD_ADDR:   w = '{OP_READ,      C_ALWAYS,    1'b0, ST_RD_CAP};
      ST_RD_CAP:    w = '{OP_CAPTURE,   C_ALWAYS,    1'b0, ST_RESULT};
      ST_CLEAR:     w = '{OP_CLEAR,     C_ALL_END,   1'b1, ST_RESULT};
      ST_RESULT:    w = '{OP_RESULT,    C_OUT_FREE,  1'b1, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/text_terminal_cursor_scroll.sv
// Text terminal of ROWS x COLUMNS 16-bit cells (color byte high, character
// byte low) with a cursor. Commands: put a character (newline moves to column
// 0 of the next row; any other character wraps a full row, scrolls when the
// cursor passes the last row and writes the cell), read one cell, clear the
// screen. Every input transaction produces exactly one output transaction
// carrying the cell read (zero for other commands) and the cursor after it.
// A small microcode table drives the datapath, one control word per cycle,
// and the cell store is a single-write RAM; a scroll also blanks the new
// bottom row, one cell at a time, and a clear rewrites every cell. Scrolling
// moves no cells: a top-row offset rotates the rows in the RAM. After reset
// the block blanks the RAM, one cell per cycle, before it takes its first
// input transaction; configuration writes are taken throughout. The output
// sits in a register, so a stalled result does not block the next input
// transaction.
module text_terminal_cursor_scroll #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [7:0]                        char_code_i,
  input  logic [$clog2(ROWS+1)-1:0]         read_row_i,
  input  logic [$clog2(COLUMNS+1)-1:0]      read_col_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [15:0]                       cell_entry_o,
  output logic [$clog2(ROWS+1)-1:0]         cursor_row_o,
  output logic [$clog2(COLUMNS+1)-1:0]      cursor_col_o
);

  localparam int unsigned RowW  = $clog2(ROWS + 1);
  localparam int unsigned ColW  = $clog2(COLUMNS + 1);
  localparam int unsigned TopW  = $clog2(ROWS);
  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(Cells);

  localparam logic [RowW-1:0] RowsR    = RowW'(ROWS);
  localparam logic [RowW-1:0] LastRow  = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] ColsC    = ColW'(COLUMNS);
  localparam logic [TopW-1:0] LastTop  = TopW'(ROWS - 1);
  localparam logic [AW-1:0]   ColsA    = AW'(COLUMNS);
  localparam logic [AW-1:0]   LastColA = AW'(COLUMNS - 1);
  localparam logic [AW-1:0]   LastCell = AW'(Cells - 1);

  // sequencer
  logic [tcs_pkg::StepW-1:0] pc_q, pc_d;
  tcs_pkg::ucode_t           cw;
  logic                      cond_true;

  // latched transaction
  logic [1:0]      cmd_q;
  logic [7:0]      char_q;
  logic [RowW-1:0] rd_row_q;
  logic [ColW-1:0] rd_col_q;

  // cursor, row rotation, sweep counter, color
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [TopW-1:0] top_q;
  logic [AW-1:0]   cnt_q;
  logic [7:0]      color_q;
  logic [15:0]     entry_q;

  // output register
  logic            out_valid_q;
  logic [15:0]     out_entry_q;
  logic [RowW-1:0] out_row_q;
  logic [ColW-1:0] out_col_q;

  logic in_acc, out_free, rd_in_range, scroll_due;
  logic [RowW-1:0] row_inc;
  logic [RowW-1:0] row_src;
  logic [ColW-1:0] col_src;
  logic [RowW:0]   prow_sum;
  logic [RowW-1:0] prow;
  logic [AW-1:0]   grid_addr;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_addr;
  logic [15:0]     ram_wdata, ram_rdata;

  assign cw = tcs_pkg::ucode_rom(pc_q);

  assign in_stall_o = (cw.op != tcs_pkg::OP_ACCEPT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign rd_in_range = (rd_row_q < RowsR) && (rd_col_q < ColsC);
  assign scroll_due  = (row_q > LastRow);
  // saturate at ROWS: a row just below the screen waits for the next character
  assign row_inc     = (row_q < RowsR) ? row_q + RowW'(1) : row_q;

  // jump condition of the current control word
  always_comb begin
    unique case (cw.cond)
      tcs_pkg::C_ALWAYS:    cond_true = 1'b1;
      tcs_pkg::C_IN_ACC:    cond_true = in_acc;
      tcs_pkg::C_CMD_PUT:   cond_true = (cmd_q == tcs_pkg::CMD_PUT);
      tcs_pkg::C_CMD_READ:  cond_true = (cmd_q == tcs_pkg::CMD_READ);
      tcs_pkg::C_CMD_CLEAR: cond_true = (cmd_q == tcs_pkg::CMD_CLEAR);
      tcs_pkg::C_NEWLINE:   cond_true = (char_q == tcs_pkg::NEWLINE_CODE);
      tcs_pkg::C_NO_SCROLL: cond_true = !scroll_due;
      tcs_pkg::C_ROW_END:   cond_true = (cnt_q == LastColA);
      tcs_pkg::C_ALL_END:   cond_true = (cnt_q == LastCell);
      tcs_pkg::C_OUT_FREE:  cond_true = out_free;
      default:              cond_true = 1'b0;
    endcase
  end

  // jump on a true condition, else hold or fall through
  always_comb begin
    priority if (cond_true) begin
      pc_d = cw.target;
    end else if (cw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + tcs_pkg::StepW'(1);
    end
  end

  // Cell address: logical row rotated by the top-row offset, times the row
  // length, plus the column. Sweeps over the whole screen use the counter.
  always_comb begin
    row_src = (cw.op == tcs_pkg::OP_READ) ? rd_row_q : row_q;
    priority case (cw.op)
      tcs_pkg::OP_READ:      col_src = rd_col_q;
      tcs_pkg::OP_BLANK_ROW: col_src = cnt_q[ColW-1:0];
      default:               col_src = col_q;
    endcase
    prow_sum  = {1'b0, row_src} + (RowW+1)'(top_q);
    prow      = (prow_sum >= (RowW+1)'(ROWS)) ? RowW'(prow_sum - (RowW+1)'(ROWS))
                                              : RowW'(prow_sum);
    grid_addr = AW'(prow) * ColsA + AW'(col_src);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = grid_addr;
    ram_wdata = {color_q, tcs_pkg::SPACE_CODE};
    unique case (cw.op)
      tcs_pkg::OP_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_q;
        ram_wdata = {tcs_pkg::RESET_COLOR, tcs_pkg::SPACE_CODE};
      end
      tcs_pkg::OP_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = cnt_q;
      end
      tcs_pkg::OP_BLANK_ROW: begin
        ram_we = 1'b1;
      end
      tcs_pkg::OP_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = {color_q, char_q};
      end
      tcs_pkg::OP_READ: begin
        ram_re = rd_in_range;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcs_ram #(
    .Width (16),
    .Depth (Cells)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // sequencer and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= tcs_pkg::ST_INIT;
      row_q <= '0;
      col_q <= '0;
      top_q <= '0;
      cnt_q <= '0;
    end else begin
      pc_q <= pc_d;
      unique case (cw.op)
        tcs_pkg::OP_INIT, tcs_pkg::OP_CLEAR, tcs_pkg::OP_BLANK_ROW: begin
          cnt_q <= cnt_q + AW'(1);
        end
        tcs_pkg::OP_ACCEPT: begin
          cnt_q <= '0;
        end
        tcs_pkg::OP_NEWLINE: begin
          row_q <= row_inc;
          col_q <= '0;
        end
        tcs_pkg::OP_WRAP: begin
          if (col_q >= ColsC) begin
            row_q <= row_inc;
            col_q <= '0;
          end
        end
        tcs_pkg::OP_SCROLL: begin
          // rotate the rows: the old top row becomes the new bottom row
          if (scroll_due) begin
            row_q <= LastRow;
            top_q <= (top_q == LastTop) ? '0 : top_q + TopW'(1);
            cnt_q <= '0;
          end
        end
        tcs_pkg::OP_WRITE: begin
          col_q <= col_q + ColW'(1);
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // latched transaction and read result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= command_i;
      char_q   <= char_code_i;
      rd_row_q <= read_row_i;
      rd_col_q <= read_col_i;
      entry_q  <= '0;
    end
    if (cw.op == tcs_pkg::OP_CAPTURE && rd_in_range) begin
      entry_q <= ram_rdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw.op == tcs_pkg::OP_RESULT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.op == tcs_pkg::OP_RESULT && out_free) begin
      out_entry_q <= entry_q;
      out_row_q   <= row_q;
      out_col_q   <= col_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_entry_o = out_entry_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= tcs_pkg::RESET_COLOR;
    end else if (psel && penable && pwrite && pready && paddr[2] == tcs_pkg::REG_TEXT_COLOR) begin
      color_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tcs_pkg::REG_TEXT_COLOR) ? {24'd0, color_q} : 32'd0;

  // cursor stays within the screen plus one overflow position each way
  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= RowsR && col_q <= ColsC)
    else $error("cursor out of bounds");

  // a scroll leaves the cursor on the last row and restarts the row sweep
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == tcs_pkg::OP_SCROLL && scroll_due) |=> (row_q == LastRow && cnt_q == '0))
    else $error("scroll did not settle cursor row");

  // every RAM write lands inside the screen
  a_ram_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_addr <= LastCell && top_q <= LastTop))
    else $error("screen write out of range");

  // a new result appears only from the result step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(cw.op == tcs_pkg::OP_RESULT))
    else $error("result loaded outside result step");

  // a character write only happens on the visible screen
  a_write_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == tcs_pkg::OP_WRITE) |-> (row_q <= LastRow && col_q < ColsC))
    else $error("character written off screen");

endmodule

FILE: design/tcs_ram.sv
module tcs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
